@@ rtl/tmpg_pkg.sv @@
// ============================================================================
// tmpg_pkg
// Shared types, address map, codes and defaults of the tile map pixel
// generator.
// ============================================================================
package tmpg_pkg;

   // Default geometry handed to the top level parameters
   localparam int TILE_COUNT_DEF  = 16;
   localparam int TILE_EDGE_DEF   = 16;
   localparam int MAP_COLUMNS_DEF = 20;
   localparam int MAP_ROWS_DEF    = 15;

   // Bus address map of the graphics memory
   localparam logic [15:0] MAP_BASE = 16'hF000;
   localparam logic [15:0] MAP_LAST = 16'hF12B;
   localparam logic [15:0] PAT_BASE = 16'hF200;
   localparam logic [15:0] PAT_LAST = 16'hF9FF;
   localparam logic [15:0] PAL_BASE = 16'hFA00;
   localparam logic [15:0] PAL_LAST = 16'hFA0F;

   // Palette geometry and RGB332 expansion factors
   localparam int PAL_DEPTH   = 16;
   localparam int RG_SCALE    = 36;
   localparam int BLUE_SCALE  = 85;

   // Transfer kinds carried on req_tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // Pixel fetch sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAP,
      ST_PAT,
      ST_PAL
   } state_type;

   // Palette write request
   typedef struct packed {
      logic       en;
      logic [3:0] index;
      logic [7:0] data;
   } pal_wr_type;

   // Expanded pixel color
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Palette contents after reset: eight primaries, the rest black
   function automatic logic [7:0] default_color(input logic [3:0] index);
      logic [7:0] color;
      case (index)
         4'd1:    color = 8'h1C;
         4'd2:    color = 8'hE0;
         4'd3:    color = 8'hFC;
         4'd4:    color = 8'h03;
         4'd5:    color = 8'h1F;
         4'd6:    color = 8'hE3;
         4'd7:    color = 8'hFF;
         default: color = 8'h00;
      endcase
      return color;
   endfunction

endpackage

@@ rtl/tmpg_ram.sv @@
// ============================================================================
// tmpg_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module tmpg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tmpg_tile_div.sv @@
// ============================================================================
// tmpg_tile_div
// Splits a screen coordinate into tile index and position inside the tile,
// by reciprocal multiplication with a remainder correction.
// ============================================================================
module tmpg_tile_div #(
   parameter int IN_W  = 9,
   parameter int EDGE  = 16,
   localparam int R_W  = $clog2(EDGE)
) (
   input  logic [IN_W-1:0] value,
   output logic [IN_W-1:0] quotient,
   output logic [R_W-1:0]  remainder
);

   // Reciprocal scaled so the truncated product is exact for every input
   localparam int SH  = IN_W + R_W + 1;
   localparam int MUL = ((1 << SH) + EDGE - 1) / EDGE;
   localparam int M_W = SH - R_W + 2;

   logic [IN_W+M_W-1:0] product;
   logic [IN_W-1:0]     q_raw;
   logic [IN_W-1:0]     rem_raw;
   logic                fix;

   always_comb begin
      product   = (IN_W+M_W)'(value) * (IN_W+M_W)'(MUL);
      q_raw     = IN_W'(product >> SH);
      rem_raw   = value - IN_W'(q_raw * EDGE);
      // one step of correction if the estimate came out low
      fix       = (rem_raw >= IN_W'(EDGE));
      quotient  = fix ? (q_raw + 1'b1) : q_raw;
      remainder = fix ? R_W'(rem_raw - IN_W'(EDGE)) : R_W'(rem_raw);
   end

endmodule

@@ rtl/tmpg_palette.sv @@
// ============================================================================
// tmpg_palette
// Sixteen entry RGB332 palette with default colors, lookup and expansion
// to 8-bit red, green and blue.
// ============================================================================
module tmpg_palette
   import tmpg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  pal_wr_type pal_wr,
   input  logic [3:0] index,
   input  logic       black,
   output rgb_type    color
);

   logic [7:0] pal_ff [PAL_DEPTH];
   logic [7:0] entry;

   // Entry storage, reset to the default colors
   always_ff @(posedge clock) begin
      for (int i = 0; i < PAL_DEPTH; i++) begin
         if (reset) begin
            pal_ff[i] <= default_color(4'(i));
         end else if (pal_wr.en && (pal_wr.index == 4'(i))) begin
            pal_ff[i] <= pal_wr.data;
         end
      end
   end

   // Lookup and RGB332 expansion
   always_comb begin
      entry       = black ? 8'h00 : pal_ff[index];
      color.red   = 8'(entry[7:5] * RG_SCALE);
      color.green = 8'(entry[4:2] * RG_SCALE);
      color.blue  = 8'(entry[1:0] * BLUE_SCALE);
   end

endmodule

@@ rtl/tile_map_pixel_generator_unit.sv @@
// ============================================================================
// tile_map_pixel_generator_unit
// Tile map video generator, 4 bits per pixel, RGB332 palette.
// ============================================================================
// Bus write transfers (req_tuser = 0) fill the tile map, pattern and palette
// stores; writes outside the three windows are dropped. A pixel request
// (req_tuser = 1) has its coordinate split registered at the accept; then
// the tile map RAM read (ST_MAP), the pattern RAM read (ST_PAT) and the
// palette lookup with the load of the result register (ST_PAL) follow. The
// two registered RAM reads lie in series and the block fetches one pixel at
// a time, so a new request enters only once the last one has been loaded.
// The result register lets the next request enter while a color waits on
// rsp_tready; ST_PAL holds while that color is unaccepted. Tile numbers of
// TILE_COUNT or more and pixels off screen give black. After reset both RAMs
// are swept to zero, one entry a cycle over max(map cells, pattern bytes)
// entries (2048 at the defaults), with req_tready low.
// ============================================================================
module tile_map_pixel_generator_unit
   import tmpg_pkg::*;
#(
   parameter int TILE_COUNT  = TILE_COUNT_DEF,
   parameter int TILE_EDGE   = TILE_EDGE_DEF,
   parameter int MAP_COLUMNS = MAP_COLUMNS_DEF,
   parameter int MAP_ROWS    = MAP_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // bus_address[15:0], write_byte[23:16], pixel_x[32:24], pixel_y[40:33]
   input  logic [47:0] req_tdata,
   // opcode[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red[7:0], green[15:8], blue[23:16], echo_x[32:24], echo_y[40:33]
   output logic [47:0] rsp_tdata
);

   // Derived geometry
   localparam int MAP_CELLS  = MAP_COLUMNS * MAP_ROWS;
   localparam int TILE_BYTES = (TILE_EDGE * TILE_EDGE + 1) / 2;
   localparam int PAT_BYTES  = TILE_COUNT * TILE_BYTES;
   localparam int SCREEN_W   = MAP_COLUMNS * TILE_EDGE;
   localparam int SCREEN_H   = MAP_ROWS * TILE_EDGE;
   localparam int MAP_AW     = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
   localparam int PAT_AW     = (PAT_BYTES > 1) ? $clog2(PAT_BYTES) : 1;
   localparam int COL_W      = (MAP_COLUMNS > 1) ? $clog2(MAP_COLUMNS) : 1;
   localparam int ROW_W      = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
   localparam int EW         = $clog2(TILE_EDGE);
   localparam int P_W        = $clog2(TILE_EDGE * TILE_EDGE);
   localparam int CLR_DEPTH  = (PAT_BYTES > MAP_CELLS) ? PAT_BYTES : MAP_CELLS;
   localparam int CLR_W      = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

   // Input fields
   logic [15:0] bus_address;
   logic [7:0]  write_byte;
   logic [8:0]  pixel_x;
   logic [7:0]  pixel_y;
   logic        req_fire;
   logic        is_pixel;

   assign bus_address = req_tdata[15:0];
   assign write_byte  = req_tdata[23:16];
   assign pixel_x     = req_tdata[32:24];
   assign pixel_y     = req_tdata[40:33];
   assign is_pixel    = (req_tuser == OP_PIXEL);
   assign req_fire    = req_tvalid && req_tready;

   // Control state
   state_type        state_ff, state_in;
   logic             clr_busy_ff;
   logic [CLR_W-1:0] clr_ff;
   logic             rsp_valid_ff;
   logic             map_rd_en;
   logic             pat_rd_en;
   logic             rsp_load;

   assign req_tready = (state_ff == ST_IDLE) && !clr_busy_ff;

   // ------------------------------------------------------------------------
   // Bus write decode
   // ------------------------------------------------------------------------
   logic [15:0] map_off;
   logic [15:0] pat_off;
   logic        map_wr;
   logic        pat_wr;
   pal_wr_type  pal_wr;

   always_comb begin
      map_off      = bus_address - MAP_BASE;
      pat_off      = bus_address - PAT_BASE;
      map_wr       = req_fire && !is_pixel && (bus_address >= MAP_BASE) &&
                     (bus_address <= MAP_LAST) && (map_off < MAP_CELLS);
      pat_wr       = req_fire && !is_pixel && (bus_address >= PAT_BASE) &&
                     (bus_address <= PAT_LAST) && (pat_off < PAT_BYTES);
      pal_wr.en    = req_fire && !is_pixel && (bus_address >= PAL_BASE) &&
                     (bus_address <= PAL_LAST);
      pal_wr.index = bus_address[3:0];
      pal_wr.data  = write_byte;
   end

   // ------------------------------------------------------------------------
   // Clearing sweep after reset
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_ff      <= '0;
      end else if (clr_busy_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == CLR_W'(CLR_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Coordinate split, registered at accept
   // ------------------------------------------------------------------------
   logic [8:0]    x_tile;
   logic [EW-1:0] x_in_tile;
   logic [7:0]    y_tile;
   logic [EW-1:0] y_in_tile;

   tmpg_tile_div #(.IN_W(9), .EDGE(TILE_EDGE)) u_div_x (
      .value     (pixel_x),
      .quotient  (x_tile),
      .remainder (x_in_tile)
   );

   tmpg_tile_div #(.IN_W(8), .EDGE(TILE_EDGE)) u_div_y (
      .value     (pixel_y),
      .quotient  (y_tile),
      .remainder (y_in_tile)
   );

   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [EW-1:0]    px_ff;
   logic [EW-1:0]    py_ff;
   logic             onscr_ff;
   logic [8:0]       echo_x_ff;
   logic [7:0]       echo_y_ff;

   always_ff @(posedge clock) begin
      if (req_fire && is_pixel) begin
         col_ff    <= COL_W'(x_tile);
         row_ff    <= ROW_W'(y_tile);
         px_ff     <= x_in_tile;
         py_ff     <= y_in_tile;
         onscr_ff  <= (pixel_x < SCREEN_W) && (pixel_y < SCREEN_H);
         echo_x_ff <= pixel_x;
         echo_y_ff <= pixel_y;
      end
   end

   // ------------------------------------------------------------------------
   // Tile map read
   // ------------------------------------------------------------------------
   logic [MAP_AW-1:0] map_cell;
   logic [P_W-1:0]    p_ff;
   logic [7:0]        tile;

   assign map_cell = MAP_AW'(row_ff * MAP_COLUMNS + col_ff);

   always_ff @(posedge clock) begin
      if (map_rd_en) begin
         p_ff <= P_W'(py_ff * TILE_EDGE + px_ff);
      end
   end

   tmpg_ram #(.WIDTH(8), .DEPTH(MAP_CELLS)) u_map_ram (
      .clock   (clock),
      .wr_en   (clr_busy_ff ? (clr_ff < MAP_CELLS) : map_wr),
      .wr_addr (clr_busy_ff ? clr_ff[MAP_AW-1:0] : map_off[MAP_AW-1:0]),
      .wr_data (clr_busy_ff ? 8'h00 : write_byte),
      .rd_en   (map_rd_en),
      .rd_addr (map_cell),
      .rd_data (tile)
   );

   // ------------------------------------------------------------------------
   // Pattern read
   // ------------------------------------------------------------------------
   logic [PAT_AW-1:0] pat_addr;
   logic              tile_ok_ff;
   logic              nib_hi_ff;
   logic [7:0]        packed_byte;

   assign pat_addr = PAT_AW'(tile * TILE_BYTES + p_ff[P_W-1:1]);

   always_ff @(posedge clock) begin
      if (pat_rd_en) begin
         tile_ok_ff <= (tile < TILE_COUNT);
         nib_hi_ff  <= p_ff[0];
      end
   end

   tmpg_ram #(.WIDTH(8), .DEPTH(PAT_BYTES)) u_pat_ram (
      .clock   (clock),
      .wr_en   (clr_busy_ff ? (clr_ff < PAT_BYTES) : pat_wr),
      .wr_addr (clr_busy_ff ? clr_ff[PAT_AW-1:0] : pat_off[PAT_AW-1:0]),
      .wr_data (clr_busy_ff ? 8'h00 : write_byte),
      .rd_en   (pat_rd_en),
      .rd_addr (pat_addr),
      .rd_data (packed_byte)
   );

   // ------------------------------------------------------------------------
   // Palette lookup
   // ------------------------------------------------------------------------
   logic [3:0] nibble;
   rgb_type    color;

   assign nibble = nib_hi_ff ? packed_byte[7:4] : packed_byte[3:0];

   tmpg_palette u_palette (
      .clock  (clock),
      .reset  (reset),
      .pal_wr (pal_wr),
      .index  (nibble),
      .black  (!(onscr_ff && tile_ok_ff)),
      .color  (color)
   );

   // ------------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_pixel) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            state_in = ST_PAT;
         end
         ST_PAT: begin
            state_in = ST_PAL;
         end
         ST_PAL: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      map_rd_en = 1'b0;
      pat_rd_en = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_MAP: begin
            map_rd_en = 1'b1;
         end
         ST_PAT: begin
            pat_rd_en = 1'b1;
         end
         ST_PAL: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------------
   logic [47:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {7'd0, echo_y_ff, echo_x_ff, color.blue, color.green, color.red};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_tready)
      else $error("request accepted during clearing sweep");

   a_pixel_starts_fetch: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_pixel) |=> (state_ff == ST_MAP))
      else $error("pixel transfer did not start a fetch");

   a_write_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_pixel) |=> req_tready)
      else $error("write transfer stalled the request channel");

   a_load_gives_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_pal_waits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PAL) && !rsp_load) |=> (state_ff == ST_PAL))
      else $error("pixel result dropped while output was full");

endmodule
